// ===== hdl/ssbck_pkg.sv =====
// Shared widths, codes and pipeline types of the scaled sprite blit core.
package ssbck_pkg;

  localparam int SPRITE_CAPACITY_DEF = 16384;
  localparam int SCREEN_W_DEF        = 1024;
  localparam int SCREEN_H_DEF        = 768;

  localparam int SRC_DIM_W  = 15;
  localparam int DST_DIM_W  = 12;
  localparam int POS_W      = 13;
  localparam int PIX_W      = 32;
  localparam int IDX_W      = 14;
  localparam int OFS_W      = 12;
  localparam int SCR_ADDR_W = 20;
  localparam int COORD_W    = 14;
  localparam int PROD_W     = OFS_W + SRC_DIM_W;
  localparam int QUO_W      = SRC_DIM_W;
  localparam int SIDX_W     = 2 * SRC_DIM_W + 1;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;

  localparam logic CMD_LOAD = 1'b0;
  localparam logic CMD_DRAW = 1'b1;

  localparam logic [CFG_IDX_W-1:0] CFG_SRC_WIDTH  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SRC_HEIGHT = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_DST_WIDTH  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_DST_HEIGHT = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_DST_LEFT   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_DST_TOP    = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_COLOR_KEY  = 3'd6;

  localparam logic [PIX_W-1:0] COLOR_KEY_RST = 32'h00FF00FF;

  // first stage after acceptance
  typedef struct packed {
    logic               vld;
    logic               draw;
    logic               kill;
    logic [IDX_W-1:0]   idx;
    logic [PIX_W-1:0]   pix;
    logic [COORD_W-1:0] scol;
    logic [COORD_W-1:0] srow;
  } stage_a_t;

  // sideband that travels next to the dividers
  typedef struct packed {
    logic                  vld;
    logic                  draw;
    logic                  kill;
    logic [IDX_W-1:0]      idx;
    logic [PIX_W-1:0]      pix;
    logic [SCR_ADDR_W-1:0] addr;
  } side_t;

  // stage that waits for the sprite read data
  typedef struct packed {
    logic                  vld;
    logic                  draw;
    logic                  kill;
    logic [SCR_ADDR_W-1:0] addr;
  } rd_t;

endpackage

// ===== hdl/scaled_sprite_blit_color_key_core.sv =====
// Top level of the nearest-neighbor scaled sprite blit with color key.
//
// One transaction per clock: busy_o is high only in the first cycle after
// reset, and a new command is taken in every cycle after that. A load
// (cmd 0) writes one sprite pixel, a draw (cmd 1) maps one destination
// offset to a source pixel by floor(offset*src/dst) in each axis and, if
// that pixel is not the color key and the screen position is on screen,
// raises result_valid_o for exactly one cycle with the screen address and
// color; loads and rejected draws give no strobe. The receiver cannot
// stall the result, so it must take every strobe. A draw passes stage A,
// two 15-stage divider pipelines (one quotient bit each), an index
// multiply stage, the registered sprite RAM read and an output register.
// Loads pass through the same pipeline and write the single RAM port at
// the stage where draws read it, so every draw sees exactly the loads
// taken before it. The sprite store is not cleared: a draw of a
// never-loaded entry returns undefined color. Configuration must only be
// written while no transaction is in flight.
module scaled_sprite_blit_color_key_core #(
  parameter int SPRITE_CAPACITY = ssbck_pkg::SPRITE_CAPACITY_DEF,
  parameter int SCREEN_W        = ssbck_pkg::SCREEN_W_DEF,
  parameter int SCREEN_H        = ssbck_pkg::SCREEN_H_DEF
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  // command channel
  input  logic                                start_i,
  output logic                                busy_o,
  input  logic                                cmd_i,
  input  logic [ssbck_pkg::IDX_W-1:0]         src_index_i,
  input  logic [ssbck_pkg::PIX_W-1:0]         src_pixel_i,
  input  logic [ssbck_pkg::OFS_W-1:0]         offset_col_i,
  input  logic [ssbck_pkg::OFS_W-1:0]         offset_row_i,
  // configuration write port
  input  logic                                cfg_we_i,
  input  logic [ssbck_pkg::CFG_IDX_W-1:0]     cfg_idx_i,
  input  logic [ssbck_pkg::CFG_DATA_W-1:0]    cfg_wdata_i,
  // result strobe
  output logic                                result_valid_o,
  output logic                                write_enable_o,
  output logic [ssbck_pkg::SCR_ADDR_W-1:0]    screen_address_o,
  output logic [ssbck_pkg::PIX_W-1:0]         color_o
);

  localparam int AW         = (SPRITE_CAPACITY > 1) ? $clog2(SPRITE_CAPACITY) : 1;
  localparam int ADDR_EXT_W = 32;
  localparam int FULL_W     = 2 * ssbck_pkg::COORD_W;
  localparam int PIPE_LAT   = ssbck_pkg::QUO_W + 4;

  localparam logic [ADDR_EXT_W-1:0] CapV = ADDR_EXT_W'(SPRITE_CAPACITY);
  localparam logic [ssbck_pkg::COORD_W-1:0] ScrW = ssbck_pkg::COORD_W'(SCREEN_W);
  localparam logic [ssbck_pkg::COORD_W-1:0] ScrH = ssbck_pkg::COORD_W'(SCREEN_H);

  // ---------------------------------------------------------------------
  // Ready flag: held busy only while coming out of reset.
  // ---------------------------------------------------------------------
  logic busy_q;
  logic accept;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b1;
    end else begin
      busy_q <= 1'b0;
    end
  end

  assign busy_o = busy_q;
  assign accept = start_i && !busy_q;

  // ---------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------
  logic [ssbck_pkg::SRC_DIM_W-1:0] src_width_q;
  logic [ssbck_pkg::SRC_DIM_W-1:0] src_height_q;
  logic [ssbck_pkg::DST_DIM_W-1:0] dst_width_q;
  logic [ssbck_pkg::DST_DIM_W-1:0] dst_height_q;
  logic [ssbck_pkg::POS_W-1:0]     dst_left_q;
  logic [ssbck_pkg::POS_W-1:0]     dst_top_q;
  logic [ssbck_pkg::PIX_W-1:0]     color_key_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      src_width_q  <= '0;
      src_height_q <= '0;
      dst_width_q  <= '0;
      dst_height_q <= '0;
      dst_left_q   <= '0;
      dst_top_q    <= '0;
      color_key_q  <= ssbck_pkg::COLOR_KEY_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        ssbck_pkg::CFG_SRC_WIDTH:  src_width_q  <= cfg_wdata_i[ssbck_pkg::SRC_DIM_W-1:0];
        ssbck_pkg::CFG_SRC_HEIGHT: src_height_q <= cfg_wdata_i[ssbck_pkg::SRC_DIM_W-1:0];
        ssbck_pkg::CFG_DST_WIDTH:  dst_width_q  <= cfg_wdata_i[ssbck_pkg::DST_DIM_W-1:0];
        ssbck_pkg::CFG_DST_HEIGHT: dst_height_q <= cfg_wdata_i[ssbck_pkg::DST_DIM_W-1:0];
        ssbck_pkg::CFG_DST_LEFT:   dst_left_q   <= cfg_wdata_i[ssbck_pkg::POS_W-1:0];
        ssbck_pkg::CFG_DST_TOP:    dst_top_q    <= cfg_wdata_i[ssbck_pkg::POS_W-1:0];
        ssbck_pkg::CFG_COLOR_KEY:  color_key_q  <= cfg_wdata_i[ssbck_pkg::PIX_W-1:0];
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------------
  // Stage A: range checks, screen coordinates, scale products.
  // ---------------------------------------------------------------------
  ssbck_pkg::stage_a_t a_d, a_q;
  logic [ssbck_pkg::PROD_W-1:0] prodx_d, prodx_q;
  logic [ssbck_pkg::PROD_W-1:0] prody_d, prody_q;
  logic empty_src;
  logic outside;

  always_comb begin
    empty_src = (src_width_q == '0) || (src_height_q == '0);
    // also covers a zero-size destination, so the dividers never matter then
    outside   = (offset_col_i >= dst_width_q) || (offset_row_i >= dst_height_q);

    a_d.vld  = accept;
    a_d.draw = (cmd_i == ssbck_pkg::CMD_DRAW);
    a_d.kill = empty_src || outside;
    a_d.idx  = src_index_i;
    a_d.pix  = src_pixel_i;
    // 14-bit two's complement holds every left/top plus offset
    a_d.scol = {dst_left_q[ssbck_pkg::POS_W-1], dst_left_q}
             + ssbck_pkg::COORD_W'(offset_col_i);
    a_d.srow = {dst_top_q[ssbck_pkg::POS_W-1], dst_top_q}
             + ssbck_pkg::COORD_W'(offset_row_i);

    prodx_d = ssbck_pkg::PROD_W'(offset_col_i) * ssbck_pkg::PROD_W'(src_width_q);
    prody_d = ssbck_pkg::PROD_W'(offset_row_i) * ssbck_pkg::PROD_W'(src_height_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_q <= '0;
    end else begin
      a_q <= a_d;
    end
  end

  always_ff @(posedge clk_i) begin
    prodx_q <= prodx_d;
    prody_q <= prody_d;
  end

  // ---------------------------------------------------------------------
  // Divider pipelines and the sideband line that runs beside them.
  // ---------------------------------------------------------------------
  logic [ssbck_pkg::QUO_W-1:0] quo_x;
  logic [ssbck_pkg::QUO_W-1:0] quo_y;

  ssbck_div #(
    .NUM_W (ssbck_pkg::PROD_W),
    .DEN_W (ssbck_pkg::DST_DIM_W),
    .QUO_W (ssbck_pkg::QUO_W)
  ) u_div_x (
    .clk_i (clk_i),
    .num_i (prodx_q),
    .den_i (dst_width_q),
    .quo_o (quo_x)
  );

  ssbck_div #(
    .NUM_W (ssbck_pkg::PROD_W),
    .DEN_W (ssbck_pkg::DST_DIM_W),
    .QUO_W (ssbck_pkg::QUO_W)
  ) u_div_y (
    .clk_i (clk_i),
    .num_i (prody_q),
    .den_i (dst_height_q),
    .quo_o (quo_y)
  );

  ssbck_pkg::side_t s_d;
  ssbck_pkg::side_t s_q [ssbck_pkg::QUO_W];
  logic              off_screen;
  logic [FULL_W-1:0] scr_addr_full;

  always_comb begin
    // sign bit set means negative; otherwise compare against the screen size
    off_screen = a_q.scol[ssbck_pkg::COORD_W-1] || a_q.srow[ssbck_pkg::COORD_W-1]
              || (a_q.scol >= ScrW) || (a_q.srow >= ScrH);
    scr_addr_full = FULL_W'(a_q.srow) * FULL_W'(ScrW) + FULL_W'(a_q.scol);

    s_d.vld  = a_q.vld;
    s_d.draw = a_q.draw;
    s_d.kill = a_q.kill || off_screen;
    s_d.idx  = a_q.idx;
    s_d.pix  = a_q.pix;
    s_d.addr = scr_addr_full[ssbck_pkg::SCR_ADDR_W-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < ssbck_pkg::QUO_W; k++) begin
        s_q[k] <= '0;
      end
    end else begin
      s_q[0] <= s_d;
      for (int k = 1; k < ssbck_pkg::QUO_W; k++) begin
        s_q[k] <= s_q[k-1];
      end
    end
  end

  // ---------------------------------------------------------------------
  // Stage C: linear source index from the two quotients.
  // ---------------------------------------------------------------------
  ssbck_pkg::side_t c_q;
  logic [ssbck_pkg::SIDX_W-1:0] sidx_d, sidx_q;

  assign sidx_d = ssbck_pkg::SIDX_W'(quo_y) * ssbck_pkg::SIDX_W'(src_width_q)
                + ssbck_pkg::SIDX_W'(quo_x);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      c_q <= '0;
    end else begin
      c_q <= s_q[ssbck_pkg::QUO_W-1];
    end
  end

  always_ff @(posedge clk_i) begin
    sidx_q <= sidx_d;
  end

  // ---------------------------------------------------------------------
  // Stage D: the sprite RAM. Loads write and draws read at the same stage,
  // so program order is kept without forwarding.
  // ---------------------------------------------------------------------
  logic [ADDR_EXT_W-1:0]       sidx_ext;
  logic [ADDR_EXT_W-1:0]       idx_ext;
  logic                        ram_we;
  logic [AW-1:0]               ram_addr;
  logic [ssbck_pkg::PIX_W-1:0] ram_rdata;
  ssbck_pkg::rd_t              d_d, d_q;

  always_comb begin
    sidx_ext = ADDR_EXT_W'(sidx_q);
    idx_ext  = ADDR_EXT_W'(c_q.idx);
    ram_we   = c_q.vld && !c_q.draw && (idx_ext < CapV);
    ram_addr = c_q.draw ? sidx_ext[AW-1:0] : idx_ext[AW-1:0];

    d_d.vld  = c_q.vld;
    d_d.draw = c_q.draw;
    d_d.kill = c_q.kill || (sidx_ext >= CapV);
    d_d.addr = c_q.addr;
  end

  ssbck_ram #(
    .WIDTH (ssbck_pkg::PIX_W),
    .DEPTH (SPRITE_CAPACITY)
  ) u_sprite_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .addr_i  (ram_addr),
    .wdata_i (c_q.pix),
    .rdata_o (ram_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      d_q <= '0;
    end else begin
      d_q <= d_d;
    end
  end

  // ---------------------------------------------------------------------
  // Output register: color key test on the read data.
  // ---------------------------------------------------------------------
  logic                             hit;
  logic                             out_vld_q;
  logic [ssbck_pkg::SCR_ADDR_W-1:0] out_addr_q;
  logic [ssbck_pkg::PIX_W-1:0]      out_color_q;

  assign hit = d_q.vld && d_q.draw && !d_q.kill && (ram_rdata != color_key_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else begin
      out_vld_q <= hit;
    end
  end

  always_ff @(posedge clk_i) begin
    out_addr_q  <= d_q.addr;
    out_color_q <= ram_rdata;
  end

  assign result_valid_o   = out_vld_q;
  assign write_enable_o   = out_vld_q;
  assign screen_address_o = out_addr_q;
  assign color_o          = out_color_q;

  // ---------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------
  // a strobe comes only from an unrejected draw in the RAM stage
  a_strobe_from_draw: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> $past(d_q.vld && d_q.draw && !d_q.kill))
    else $error("result strobe without a live draw behind it");

  // a sprite write never turns into a screen write
  a_ram_write_silent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ram_we |-> ##2 !result_valid_o)
    else $error("sprite load produced a result");

  // an accepted load yields no strobe at the draw latency
  a_load_no_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && (cmd_i == ssbck_pkg::CMD_LOAD)) |-> ##PIPE_LAT !result_valid_o)
    else $error("load transaction produced a result");

  // a draw rejected at entry stays rejected down the pipe
  a_kill_sticks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (a_q.vld && a_q.kill) |-> ##(PIPE_LAT-1) !result_valid_o)
    else $error("rejected draw produced a result");

endmodule

// ===== hdl/ssbck_ram.sv =====
// Generic single-port RAM with registered read.
module ssbck_ram #(
  parameter int WIDTH = ssbck_pkg::PIX_W,
  parameter int DEPTH = ssbck_pkg::SPRITE_CAPACITY_DEF,
  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    addr_i,
  input  logic [WIDTH-1:0] wdata_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_q <= mem_q[addr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== hdl/ssbck_div.sv =====
// Pipelined restoring divider, one quotient bit per stage.
module ssbck_div #(
  parameter int NUM_W = ssbck_pkg::PROD_W,
  parameter int DEN_W = ssbck_pkg::DST_DIM_W,
  parameter int QUO_W = ssbck_pkg::QUO_W
) (
  input  logic             clk_i,
  input  logic [NUM_W-1:0] num_i,
  input  logic [DEN_W-1:0] den_i,  // static while items are in flight
  output logic [QUO_W-1:0] quo_o
);

  // caller guarantees num_i < den_i * 2**QUO_W
  logic [NUM_W-1:0] rem_q [QUO_W];
  logic [QUO_W-1:0] quo_q [QUO_W];

  for (genvar k = 0; k < QUO_W; k++) begin : g_stage
    localparam int Bit = QUO_W - 1 - k;
    logic [NUM_W-1:0] rem_in;
    logic [NUM_W-1:0] trial;
    logic [QUO_W-1:0] quo_in;
    logic             ge;

    if (k == 0) begin : g_first
      assign rem_in = num_i;
      assign quo_in = '0;
    end else begin : g_next
      assign rem_in = rem_q[k-1];
      assign quo_in = quo_q[k-1];
    end

    assign trial = NUM_W'(den_i) << Bit;
    assign ge    = rem_in >= trial;

    always_ff @(posedge clk_i) begin
      rem_q[k] <= ge ? (rem_in - trial) : rem_in;
      quo_q[k] <= quo_in | (QUO_W'(ge) << Bit);
    end
  end

  assign quo_o = quo_q[QUO_W-1];

endmodule
